// ===== src/j1939ac_pkg.sv =====
// ----------------------------------------------------------------------------
// J1939 address claim package
// Shared types and constants for the static-address claim block.
// ----------------------------------------------------------------------------
package j1939ac_pkg;

   localparam int NAME_W  = 64;
   localparam int ADDR_W  = 8;
   localparam int WAIT_W  = 16;
   localparam int ID_W    = 29;
   localparam int LEN_W   = 4;
   localparam int DATA_W  = 64;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 96;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NAME    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAIM_WAIT  = 2'd2;

   localparam logic [NAME_W-1:0] OWN_NAME_RESET    = 64'h8122_8409_E900_0001;
   localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 8'h80;
   localparam logic [WAIT_W-1:0] CLAIM_WAIT_RESET  = 16'd250;

   localparam logic [7:0]        PF_CLAIM    = 8'hEE;
   localparam logic [7:0]        PF_REQUEST  = 8'hEA;
   localparam logic [7:0]        ADDR_NULL   = 8'hFE;
   localparam logic [7:0]        ADDR_GLOBAL = 8'hFF;
   localparam logic [ID_W-1:0]   CLAIM_BASE  = 29'h18EE_FF00;
   localparam logic [WAIT_W-1:0] TIMER_MAX   = 16'hFFFF;
   localparam logic [LEN_W-1:0]  REQ_MIN_LEN = 4'd3;
   localparam logic [23:0]       REQ_PGN     = 24'h00_EE00;

   typedef enum logic {
      FUNC_FRAME = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

   typedef enum logic {
      KIND_CLAIM  = 1'b0,
      KIND_CANNOT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [NAME_W-1:0] own_name;
      logic [ADDR_W-1:0] own_address;
      logic [WAIT_W-1:0] claim_wait_ms;
   } cfg_type;

   typedef struct packed {
      func_type          func;
      logic              ignition;
      logic              frame_ext;
      logic [ID_W-1:0]   frame_id;
      logic [LEN_W-1:0]  frame_len;
      logic [DATA_W-1:0] frame_data;
   } item_type;

   typedef struct packed {
      logic              tx_send;
      kind_type          tx_kind;
      logic [ID_W-1:0]   tx_id;
      logic [DATA_W-1:0] tx_data;
      logic              is_claimed;
      logic              has_failed;
   } result_type;

endpackage

// ===== src/j1939ac_csr.sv =====
// ----------------------------------------------------------------------------
// J1939 address claim register file
// Holds the device NAME, the source address and the claim wait time.
// ----------------------------------------------------------------------------
module j1939ac_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [j1939ac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [j1939ac_pkg::NAME_W-1:0]      csr_data,
   output j1939ac_pkg::cfg_type                cfg
);

   j1939ac_pkg::cfg_type cfg_ff;
   j1939ac_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            j1939ac_pkg::CSR_OWN_NAME: begin
               cfg_in.own_name = csr_data;
            end
            j1939ac_pkg::CSR_OWN_ADDRESS: begin
               cfg_in.own_address = csr_data[j1939ac_pkg::ADDR_W-1:0];
            end
            j1939ac_pkg::CSR_CLAIM_WAIT: begin
               cfg_in.claim_wait_ms = csr_data[j1939ac_pkg::WAIT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_name      <= j1939ac_pkg::OWN_NAME_RESET;
         cfg_ff.own_address   <= j1939ac_pkg::OWN_ADDRESS_RESET;
         cfg_ff.claim_wait_ms <= j1939ac_pkg::CLAIM_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/j1939ac_engine.sv =====
// ----------------------------------------------------------------------------
// J1939 address claim engine
// Claim state, wait timer and the per-beat decision logic.
// ----------------------------------------------------------------------------
module j1939ac_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  j1939ac_pkg::item_type     item,
   input  j1939ac_pkg::cfg_type      cfg,
   output j1939ac_pkg::result_type   result
);

   logic                            claimed_ff, claimed_in;
   logic                            failed_ff, failed_in;
   logic                            prev_ign_ff, prev_ign_in;
   logic [j1939ac_pkg::WAIT_W-1:0]  timer_ff, timer_in;

   always_comb begin
      logic       rising;
      logic       falling;
      logic       frame_ok;
      logic [7:0] pf;
      logic [7:0] ps;
      logic [7:0] sa;
      logic       claim_hit;
      logic       req_hit;
      logic       send;
      j1939ac_pkg::kind_type kind;

      pf = item.frame_id[23:16];
      ps = item.frame_id[15:8];
      sa = item.frame_id[7:0];
      send = 1'b0;
      kind = j1939ac_pkg::KIND_CLAIM;

      timer_in = timer_ff;
      if (item.func == j1939ac_pkg::FUNC_TICK && timer_ff != j1939ac_pkg::TIMER_MAX) begin
         timer_in = timer_ff + 16'd1;
      end

      rising  = item.ignition & ~prev_ign_ff;
      falling = ~item.ignition & prev_ign_ff;
      claimed_in = claimed_ff;
      failed_in  = failed_ff;
      if (rising || falling) begin
         claimed_in = 1'b0;
         failed_in  = 1'b0;
      end
      if (rising) begin
         send     = 1'b1;
         timer_in = '0;
      end
      prev_ign_in = item.ignition;

      frame_ok = (item.func == j1939ac_pkg::FUNC_FRAME) && item.ignition && !rising
                 && item.frame_ext;
      claim_hit = frame_ok && pf == j1939ac_pkg::PF_CLAIM && sa == cfg.own_address;
      req_hit   = frame_ok && pf == j1939ac_pkg::PF_REQUEST
                  && (ps == cfg.own_address || ps == j1939ac_pkg::ADDR_GLOBAL)
                  && item.frame_len >= j1939ac_pkg::REQ_MIN_LEN
                  && item.frame_data[23:0] == j1939ac_pkg::REQ_PGN;

      if (claim_hit) begin
         send       = 1'b1;
         claimed_in = 1'b0;
         if (item.frame_data < cfg.own_name) begin
            failed_in = 1'b1;
            kind      = j1939ac_pkg::KIND_CANNOT;
         end else begin
            timer_in = '0;
         end
      end else if (req_hit) begin
         send = 1'b1;
         if (failed_ff) begin
            kind = j1939ac_pkg::KIND_CANNOT;
         end
      end

      if (item.ignition && !claimed_in && !failed_in && timer_in >= cfg.claim_wait_ms) begin
         claimed_in = 1'b1;
      end

      result.tx_send    = send;
      result.tx_kind    = send ? kind : j1939ac_pkg::KIND_CLAIM;
      result.tx_id      = '0;
      result.tx_data    = '0;
      if (send) begin
         result.tx_data = cfg.own_name;
         if (kind == j1939ac_pkg::KIND_CANNOT) begin
            result.tx_id = j1939ac_pkg::CLAIM_BASE | {21'd0, j1939ac_pkg::ADDR_NULL};
         end else begin
            result.tx_id = j1939ac_pkg::CLAIM_BASE | {21'd0, cfg.own_address};
         end
      end
      result.is_claimed = claimed_in;
      result.has_failed = failed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         claimed_ff  <= 1'b0;
         failed_ff   <= 1'b0;
         prev_ign_ff <= 1'b0;
         timer_ff    <= '0;
      end else if (step_en) begin
         claimed_ff  <= claimed_in;
         failed_ff   <= failed_in;
         prev_ign_ff <= prev_ign_in;
         timer_ff    <= timer_in;
      end
   end

endmodule

// ===== src/j1939_address_claim_top.sv =====
// ----------------------------------------------------------------------------
// J1939 address claim, top level
// Static-address claim handling for one bus: an input register, the claim
// engine and a result register.
//
//   Channel   Direction  Handshake              Content
//   req_      in         req_tvalid/tready      received frame or ms tick
//   rsp_      out        rsp_tvalid/tready      transmit request and flags
//   csr_      in         csr_valid/ready        register index and data
//
// One beat is accepted per cycle unless a stalled result holds the input
// register; a beat's result is registered as it leaves the input register.
// The engine updates its state as a beat moves from the input register to
// the result register, so the throughput is set by that single step.
// Reset is synchronous and clears the valid flags, the claim state and the
// configuration registers to their defaults. A stalled result stops the
// engine; the input register still takes one beat if it is empty and holds
// it until the result register drains.
// ----------------------------------------------------------------------------
module j1939_address_claim_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // ignition, frame_ext, frame_id, frame_len, frame_data, zero pad
   input  logic [j1939ac_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tx_send, tx_id, tx_data, is_claimed, has_failed
   output logic [j1939ac_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // tx_kind
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [j1939ac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [j1939ac_pkg::NAME_W-1:0]         csr_data
);

   j1939ac_pkg::cfg_type    cfg;
   j1939ac_pkg::item_type   item_ff, item_in;
   j1939ac_pkg::result_type result;
   j1939ac_pkg::result_type result_ff;
   logic                    item_valid_ff;
   logic                    rsp_valid_ff;
   logic                    advance;
   logic                    req_take;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in.func       = j1939ac_pkg::func_type'(req_tuser);
      item_in.ignition   = req_tdata[0];
      item_in.frame_ext  = req_tdata[1];
      item_in.frame_id   = req_tdata[30:2];
      item_in.frame_len  = req_tdata[34:31];
      item_in.frame_data = req_tdata[98:35];
   end

   j1939ac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   j1939ac_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.tx_kind;
   assign rsp_tdata  = {result_ff.has_failed, result_ff.is_claimed, result_ff.tx_data,
                        result_ff.tx_id, result_ff.tx_send};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address claim block testbench
// Drives received frames and millisecond ticks into the claim block and
// checks every response beat against a cycle-free model of the claim state.
// Directed tests cover ignition edges, frame filtering, competing claims,
// requests and register extremes. Random traffic then runs through several
// register settings, with random gaps on both streams in all but the last.
// ----------------------------------------------------------------------------
module testbench;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [j1939ac_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b1;
   logic [j1939ac_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [j1939ac_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [j1939ac_pkg::NAME_W-1:0]      csr_data = '0;

   j1939ac_pkg::cfg_type model_cfg = '{own_name: j1939ac_pkg::OWN_NAME_RESET,
                                       own_address: j1939ac_pkg::OWN_ADDRESS_RESET,
                                       claim_wait_ms: j1939ac_pkg::CLAIM_WAIT_RESET};
   logic                           addr_claimed = 1'b0;
   logic                           addr_lost = 1'b0;
   logic                           ign_prev = 1'b0;
   logic [j1939ac_pkg::WAIT_W-1:0] model_wait = '0;

   j1939ac_pkg::result_type expected_tx [$];
   int         fail_count = 0;
   int         stall_count = 0;
   bit         idle_on = 1'b1;
   logic       ign_level = 1'b1;

   j1939_address_claim_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic j1939ac_pkg::result_type predict_claim_state(
         input j1939ac_pkg::item_type it);
      j1939ac_pkg::result_type r;
      logic                    rising;
      logic                    send;
      j1939ac_pkg::kind_type   kind;
      logic [7:0]              pf;
      logic [7:0]              ps;
      logic [7:0]              sa;
      r = '0;
      send = 1'b0;
      kind = j1939ac_pkg::KIND_CLAIM;
      if (it.func == j1939ac_pkg::FUNC_TICK && model_wait != j1939ac_pkg::TIMER_MAX)
         model_wait = model_wait + 1'b1;
      rising = it.ignition && !ign_prev;
      if (rising) begin
         addr_claimed = 1'b0;
         addr_lost = 1'b0;
         send = 1'b1;
         kind = j1939ac_pkg::KIND_CLAIM;
         model_wait = '0;
      end
      if (!it.ignition && ign_prev) begin
         addr_claimed = 1'b0;
         addr_lost = 1'b0;
      end
      ign_prev = it.ignition;
      if (it.func == j1939ac_pkg::FUNC_FRAME && it.ignition && !rising && it.frame_ext) begin
         pf = it.frame_id[23:16];
         ps = it.frame_id[15:8];
         sa = it.frame_id[7:0];
         if (pf == j1939ac_pkg::PF_CLAIM && sa == model_cfg.own_address) begin
            send = 1'b1;
            if (it.frame_data < model_cfg.own_name) begin
               addr_claimed = 1'b0;
               addr_lost = 1'b1;
               kind = j1939ac_pkg::KIND_CANNOT;
            end else begin
               kind = j1939ac_pkg::KIND_CLAIM;
               model_wait = '0;
               addr_claimed = 1'b0;
            end
         end else if (pf == j1939ac_pkg::PF_REQUEST
                      && (ps == model_cfg.own_address || ps == j1939ac_pkg::ADDR_GLOBAL)
                      && it.frame_len >= j1939ac_pkg::REQ_MIN_LEN
                      && it.frame_data[23:0] == j1939ac_pkg::REQ_PGN) begin
            send = 1'b1;
            kind = addr_lost ? j1939ac_pkg::KIND_CANNOT : j1939ac_pkg::KIND_CLAIM;
         end
      end
      if (it.ignition && !addr_claimed && !addr_lost && model_wait >= model_cfg.claim_wait_ms)
         addr_claimed = 1'b1;
      if (send) begin
         r.tx_send = 1'b1;
         r.tx_kind = kind;
         r.tx_id = (kind == j1939ac_pkg::KIND_CANNOT)
                   ? (j1939ac_pkg::CLAIM_BASE | j1939ac_pkg::ID_W'(j1939ac_pkg::ADDR_NULL))
                   : (j1939ac_pkg::CLAIM_BASE | j1939ac_pkg::ID_W'(model_cfg.own_address));
         r.tx_data = model_cfg.own_name;
      end
      r.is_claimed = addr_claimed;
      r.has_failed = addr_lost;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic j1939ac_pkg::item_type tick_item(input logic ign);
      j1939ac_pkg::item_type it;
      logic [31:0]           r;
      r = $urandom;
      it.func = j1939ac_pkg::FUNC_TICK;
      it.ignition = ign;
      it.frame_ext = r[29];
      it.frame_id = r[28:0];
      it.frame_len = r[3:0];
      it.frame_data = rand64();
      return it;
   endfunction

   function automatic j1939ac_pkg::item_type frame_item(
         input logic ign, input logic ext,
         input logic [j1939ac_pkg::ID_W-1:0] id,
         input logic [j1939ac_pkg::LEN_W-1:0] len,
         input logic [j1939ac_pkg::DATA_W-1:0] data);
      j1939ac_pkg::item_type it;
      it.func = j1939ac_pkg::FUNC_FRAME;
      it.ignition = ign;
      it.frame_ext = ext;
      it.frame_id = id;
      it.frame_len = len;
      it.frame_data = data;
      return it;
   endfunction

   function automatic logic [j1939ac_pkg::ID_W-1:0] claim_id(input logic [7:0] sa);
      logic [31:0] r;
      r = $urandom;
      r[23:16] = j1939ac_pkg::PF_CLAIM;
      r[7:0] = sa;
      return r[j1939ac_pkg::ID_W-1:0];
   endfunction

   function automatic logic [j1939ac_pkg::ID_W-1:0] request_id(input logic [7:0] ps);
      logic [31:0] r;
      r = $urandom;
      r[23:16] = j1939ac_pkg::PF_REQUEST;
      r[15:8] = ps;
      return r[j1939ac_pkg::ID_W-1:0];
   endfunction

   function automatic logic [j1939ac_pkg::DATA_W-1:0] request_data();
      logic [63:0] d;
      d = rand64();
      d[23:0] = j1939ac_pkg::REQ_PGN;
      return d;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      j1939ac_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tx.size() == 0) begin
            $error("response beat with no expected result");
            fail_count++;
         end else begin
            want = expected_tx.pop_front();
            check_field("tx_send", 64'(want.tx_send), 64'(rsp_tdata[0]));
            check_field("tx_kind", 64'(want.tx_kind), 64'(rsp_tuser));
            check_field("tx_id", 64'(want.tx_id), 64'(rsp_tdata[29:1]));
            check_field("tx_data", want.tx_data, rsp_tdata[93:30]);
            check_field("is_claimed", 64'(want.is_claimed), 64'(rsp_tdata[94]));
            check_field("has_failed", 64'(want.has_failed), 64'(rsp_tdata[95]));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_count != 0) begin
         stall_count <= stall_count - 1;
         rsp_tready <= (stall_count == 1);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_count <= $urandom_range(1, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_bus_item(input j1939ac_pkg::item_type it);
      req_tvalid <= 1'b1;
      req_tuser <= it.func;
      req_tdata <= {5'b0, it.frame_data, it.frame_len, it.frame_id, it.frame_ext, it.ignition};
      do @(posedge clock); while (!req_tready);
      expected_tx.push_back(predict_claim_state(it));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_tx.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [63:0] name_v, input logic [7:0] addr_v,
                               input logic [15:0] wait_v);
      logic [j1939ac_pkg::CSR_IDX_W-1:0] idx [3];
      logic [63:0]                       val [3];
      idx = '{j1939ac_pkg::CSR_OWN_NAME, j1939ac_pkg::CSR_OWN_ADDRESS,
              j1939ac_pkg::CSR_CLAIM_WAIT};
      val = '{name_v, {56'b0, addr_v}, {48'b0, wait_v}};
      drain_results();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         unique case (idx[i])
            j1939ac_pkg::CSR_OWN_NAME:    model_cfg.own_name = val[i];
            j1939ac_pkg::CSR_OWN_ADDRESS: model_cfg.own_address = val[i][7:0];
            default:                      model_cfg.claim_wait_ms = val[i][15:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_filters_and_edges();
      send_bus_item(tick_item(1'b0));
      send_bus_item(frame_item(1'b0, 1'b1, claim_id(model_cfg.own_address), 4'd8, '0));
      // A lower NAME arriving on the rising edge is dropped; only the claim goes out.
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(model_cfg.own_address), 4'd8, '0));
      send_bus_item(frame_item(1'b1, 1'b0, claim_id(model_cfg.own_address), 4'd8, '0));
      send_bus_item(tick_item(1'b0));
   endtask

   task automatic test_competing_claims();
      send_bus_item(tick_item(1'b1));
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(model_cfg.own_address), 4'd8,
                               model_cfg.own_name));
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(model_cfg.own_address), 4'd0, '1));
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(model_cfg.own_address), 4'd8,
                               model_cfg.own_name - 64'd1));
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(model_cfg.own_address), 4'd8, '0));
   endtask

   task automatic test_requests();
      send_bus_item(frame_item(1'b1, 1'b1, request_id(j1939ac_pkg::ADDR_GLOBAL), 4'd3,
                               request_data()));
      send_bus_item(tick_item(1'b0));
      send_bus_item(tick_item(1'b1));
      send_bus_item(frame_item(1'b1, 1'b1, request_id(model_cfg.own_address), 4'd15,
                               request_data()));
      send_bus_item(frame_item(1'b1, 1'b1, request_id(model_cfg.own_address), 4'd2,
                               request_data()));
      send_bus_item(frame_item(1'b1, 1'b1, request_id(model_cfg.own_address + 8'd1), 4'd8,
                               request_data()));
   endtask

   task automatic test_wait_and_address_extremes();
      write_config('0, 8'hFF, 16'd0);
      send_bus_item(tick_item(1'b0));
      send_bus_item(tick_item(1'b1));
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(8'hFF), 4'd8, '0));
      send_bus_item(frame_item(1'b1, 1'b1, request_id(8'hFF), 4'd8, request_data()));
      write_config('1, 8'hFE, 16'd1);
      send_bus_item(frame_item(1'b1, 1'b1, claim_id(8'hFE), 4'd8, '1 - 64'd1));
      write_config(rand64(), j1939ac_pkg::OWN_ADDRESS_RESET, 16'hFFFF);
      send_bus_item(tick_item(1'b0));
      send_bus_item(tick_item(1'b1));
      send_bus_item(tick_item(1'b1));
   endtask

   function automatic j1939ac_pkg::item_type random_item();
      int unsigned pick;
      logic [31:0] r;
      logic [63:0] d;
      logic [7:0]  ps;
      logic [3:0]  len;
      logic        ext;
      r = $urandom;
      if ($urandom_range(0, 99) < (ign_level ? 6 : 35))
         ign_level = ~ign_level;
      ext = ($urandom_range(0, 19) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)
         return tick_item(ign_level);
      if (pick < 55) begin
         case ($urandom_range(0, 5))
            0:       d = model_cfg.own_name;
            1:       d = model_cfg.own_name + 64'd1;
            2:       d = model_cfg.own_name - 64'd1;
            3:       d = '0;
            4:       d = '1;
            default: d = rand64();
         endcase
         return frame_item(ign_level, ext, claim_id(model_cfg.own_address), r[3:0], d);
      end
      if (pick < 75) begin
         case ($urandom_range(0, 4))
            0:       ps = j1939ac_pkg::ADDR_GLOBAL;
            1:       ps = r[15:8];
            default: ps = model_cfg.own_address;
         endcase
         len = ($urandom_range(0, 3) == 0) ? r[7:4] : 4'($urandom_range(3, 8));
         d = ($urandom_range(0, 6) == 0) ? rand64() : request_data();
         return frame_item(ign_level, ext, request_id(ps), len, d);
      end
      if (pick < 82)
         return frame_item(ign_level, ext, claim_id(r[15:8]), r[3:0], rand64());
      return frame_item(ign_level, r[31], r[28:0], r[3:0], rand64());
   endfunction

   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_config(rand64(), 8'($urandom_range(0, 253)), 16'($urandom_range(1, 20)));
            1: write_config('0, 8'hFF, 16'd0);
            2: write_config('1, 8'h00, 16'hFFFF);
            3: write_config(rand64(), 8'hFE, 16'($urandom_range(5, 40)));
            default: begin
               idle_on = 1'b0;
               write_config(rand64(), 8'($urandom_range(0, 255)), 16'($urandom_range(1, 10)));
            end
         endcase
         repeat (100) send_bus_item(random_item());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_filters_and_edges();
      test_competing_claims();
      test_requests();
      test_wait_and_address_extremes();
      test_random_traffic();
      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/j1939ac_pkg.sv
src/j1939ac_csr.sv
src/j1939ac_engine.sv
src/j1939_address_claim_top.sv
tb/testbench.sv
